// ===== hw/rtl/swfs_pkg.sv =====
`default_nettype none

package swfs_pkg;

   localparam int unsigned TICK_W     = 8;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SHIFT_W    = 10;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 8;

   localparam logic [SLOT_W-1:0] ACK_SLOT = 4'd10;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_START_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_HOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_READ_HALF  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY   = 2'd3;

   localparam logic [TICK_W-1:0] START_LOW_RESET  = 8'd6;
   localparam logic [TICK_W-1:0] WRITE_HOLD_RESET = 8'd60;
   localparam logic [TICK_W-1:0] READ_HALF_RESET  = 8'd30;
   localparam logic [TICK_W-1:0] RECOVERY_RESET   = 8'd10;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      PH_START   = 2'd0,
      PH_DECIDE  = 2'd1,
      PH_SAMPLE  = 2'd2,
      PH_RELEASE = 2'd3
   } phase_type;

   typedef struct packed {
      logic [TICK_W-1:0] start_low;
      logic [TICK_W-1:0] write_hold;
      logic [TICK_W-1:0] read_half;
      logic [TICK_W-1:0] recovery;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] send_byte;
      logic              line_level;
   } req_type;

   typedef struct packed {
      logic line_pull_low;
      logic busy_res;
      logic done_res;
      logic acked;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/swfs_csr.sv =====
`default_nettype none

module swfs_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [swfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [swfs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output swfs_pkg::cfg_type                       cfg
);
   import swfs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_LOW:  cfg_in.start_low  = csr_wdata;
            CSR_WRITE_HOLD: cfg_in.write_hold = csr_wdata;
            CSR_READ_HALF:  cfg_in.read_half  = csr_wdata;
            CSR_RECOVERY:   cfg_in.recovery   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low  <= START_LOW_RESET;
         cfg_ff.write_hold <= WRITE_HOLD_RESET;
         cfg_ff.read_half  <= READ_HALF_RESET;
         cfg_ff.recovery   <= RECOVERY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/swfs_engine.sv =====
`default_nettype none

module swfs_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire swfs_pkg::req_type item,
   input  wire swfs_pkg::cfg_type cfg,
   output swfs_pkg::rsp_type      result
);
   import swfs_pkg::*;

   phase_type          phase_ff,   phase_in;
   logic [TICK_W-1:0]  count_ff,   count_in;
   logic [SHIFT_W-1:0] shifter_ff, shifter_in;
   logic [SLOT_W-1:0]  slot_ff,    slot_in;
   logic               sending_ff, sending_in;
   logic               ack_ff,     ack_in;
   logic               drive_ff,   drive_in;
   logic               done;

   // advance the slot sequencer by one word
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      shifter_in = shifter_ff;
      slot_in    = slot_ff;
      sending_in = sending_ff;
      ack_in     = ack_ff;
      drive_in   = drive_ff;
      done       = 1'b0;
      if (step_en) begin
         if (item.op == OP_START) begin
            if (!sending_ff) begin
               sending_in = 1'b1;
               phase_in   = PH_START;
               slot_in    = '0;
               shifter_in = {{(SHIFT_W-BYTE_W){1'b0}}, item.send_byte};
               ack_in     = 1'b0;
               drive_in   = 1'b0;
               count_in   = cfg.recovery;
            end
         end else if (sending_ff) begin
            if (count_ff <= TICK_W'(1)) begin
               count_in = '0;
               unique case (phase_ff)
                  PH_START: begin
                     drive_in = 1'b1;
                     count_in = cfg.start_low;
                     phase_in = PH_DECIDE;
                  end
                  PH_DECIDE: begin
                     if (slot_ff >= ACK_SLOT) begin
                        drive_in = 1'b0;
                        count_in = cfg.read_half;
                        phase_in = PH_SAMPLE;
                     end else begin
                        drive_in   = ~shifter_ff[0];
                        shifter_in = shifter_ff >> 1;
                        count_in   = cfg.write_hold;
                        phase_in   = PH_RELEASE;
                     end
                  end
                  PH_SAMPLE: begin
                     ack_in   = ~item.line_level;
                     count_in = cfg.read_half;
                     phase_in = PH_RELEASE;
                  end
                  PH_RELEASE: begin
                     drive_in = 1'b0;
                     phase_in = PH_START;
                     count_in = cfg.recovery;
                     if (slot_ff >= ACK_SLOT) begin
                        sending_in = 1'b0;
                        done       = 1'b1;
                     end else begin
                        slot_in = slot_ff + SLOT_W'(1);
                     end
                  end
                  default: ;
               endcase
            end else begin
               count_in = count_ff - TICK_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_START;
         count_ff   <= '0;
         shifter_ff <= '0;
         slot_ff    <= '0;
         sending_ff <= 1'b0;
         ack_ff     <= 1'b0;
         drive_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         count_ff   <= count_in;
         shifter_ff <= shifter_in;
         slot_ff    <= slot_in;
         sending_ff <= sending_in;
         ack_ff     <= ack_in;
         drive_ff   <= drive_in;
      end
   end

   assign result.line_pull_low = drive_in;
   assign result.busy_res      = sending_in;
   assign result.done_res      = done;
   assign result.acked         = done & ack_in;

endmodule

`default_nettype wire

// ===== hw/rtl/single_wire_frame_sender.sv =====
`default_nettype none

// Channel   Direction  Handshake           Word
// req_      in         req_valid/stall     op, send_byte, line_level
// rsp_      out        rsp_valid/stall     line_pull_low, busy_res, done_res, acked
// csr_      in         csr_wr_en           index 0..3, 8-bit data
//
// One request word in, one response word out, one word per cycle sustained while
// rsp_ is not stalled. A word passes the input register, then the sequencer step that
// fills the response register. Reset is synchronous: config returns to its
// defaults and the sequencer goes idle with the line released. A stall on
// rsp_ holds the response register and then back-pressures req_ once the
// input register is also full.

module single_wire_frame_sender (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_op,
   input  wire logic [swfs_pkg::BYTE_W-1:0]       req_send_byte,
   input  wire logic                              req_line_level,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_line_pull_low,
   output logic                                   rsp_busy_res,
   output logic                                   rsp_done_res,
   output logic                                   rsp_acked,
   input  wire logic                              csr_wr_en,
   input  wire logic [swfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [swfs_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import swfs_pkg::*;

   cfg_type cfg;
   req_type item_ff, item_in;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type step_result;
   logic    req_take;
   logic    step_en;

   swfs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance the held word into the sequencer whenever the response slot frees up
   assign step_en   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~step_en;
   assign req_take  = req_valid & ~req_stall;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_take) begin
         item_in.op         = op_type'(req_op);
         item_in.send_byte  = req_send_byte;
         item_in.line_level = req_line_level;
         in_valid_in        = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end
   end

   swfs_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // hold the response until taken; load a fresh one on every step
   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_in       = step_result;
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_line_pull_low = out_ff.line_pull_low;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_done_res      = out_ff.done_res;
   assign rsp_acked         = out_ff.acked;

   // a frame ends with the sender idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done reported while still busy");

   // acknowledge only reported on the word that ends the frame
   a_ack_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_acked |-> rsp_done_res)
      else $error("acked without done");

   // back-pressure only when both stages are full and the output is stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("request stalled without a full pipeline");

   // a stepped word always lands in the response register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> out_valid_ff)
      else $error("stepped word lost");

endmodule

`default_nettype wire
